// ===== sv/mewd_pkg.sv =====
package mewd_pkg;

   // most results one header byte can cause
   localparam int MaxResults = 3;

   // results of one accepted byte, handed from the parser to the output side
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;   // decoded bytes, first in entry 0
      logic [1:0]                 count;   // number of decoded bytes, 0 to 3
      logic                       last;    // byte closed the text
   } group_type;

endpackage

// ===== sv/mewd_front.sv =====
module mewd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                push,
   output mewd_pkg::group_type group
);

   typedef enum logic [3:0] {
      M_PLAIN   = 4'd0,
      M_SAWEQ   = 4'd1,
      M_CHARSET = 4'd2,
      M_LETTER  = 4'd3,
      M_SKIP_Q  = 4'd4,
      M_SKIP_B  = 4'd5,
      M_SKIP_X  = 4'd6,
      M_B_DATA  = 4'd7,
      M_B_QMARK = 4'd8,
      M_B_PAD   = 4'd9,
      M_B_PADQ  = 4'd10,
      M_Q_DATA  = 4'd11,
      M_Q_QMARK = 4'd12,
      M_Q_EQ    = 4'd13,
      M_Q_HEX   = 4'd14
   } mode_type;

   typedef struct packed {
      logic [1:0][7:0] b;
      logic [1:0]      n;
   } flush_type;

   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_QM = 8'h3F;
   localparam logic [7:0] CH_US = 8'h5F;
   localparam logic [7:0] CH_SP = 8'h20;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_UQ = 8'h51;
   localparam logic [7:0] CH_LQ = 8'h71;
   localparam logic [7:0] CH_UB = 8'h42;
   localparam logic [7:0] CH_LB = 8'h62;
   localparam logic [7:0] NoSextet  = 8'd100;
   localparam logic [7:0] SextetEnd = 8'd255;

   function automatic logic [7:0] sextet_of(input logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h41 && c <= 8'h5A)      r = c - 8'h41;
      else if (c >= 8'h61 && c <= 8'h7A) r = c - 8'h61 + 8'd26;
      else if (c >= 8'h30 && c <= 8'h39) r = c - 8'h30 + 8'd52;
      else if (c == 8'h2B)               r = 8'd62;
      else if (c == 8'h2F)               r = 8'd63;
      else if (c == CH_EQ || c == 8'h00 || c == 8'hFF) r = SextetEnd;
      else                               r = NoSextet;
      return r;
   endfunction

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_of(input logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h30 && c <= 8'h39)      r = c - 8'h30;
      else if (c >= 8'h41 && c <= 8'h46) r = c - 8'h41 + 8'd10;
      else if (c >= 8'h61 && c <= 8'h66) r = c - 8'h61 + 8'd10;
      else                               r = 8'h10;
      return r[4:0];
   endfunction

   // bytes left in a partial base64 group
   function automatic flush_type flush_of(input logic [17:0] acc, input logic [1:0] cnt);
      flush_type f;
      f.b[0] = (cnt == 2'd3) ? acc[17:10] : acc[11:4];
      f.b[1] = acc[9:2];
      case (cnt)
         2'd2:    f.n = 2'd1;
         2'd3:    f.n = 2'd2;
         default: f.n = 2'd0;
      endcase
      return f;
   endfunction

   mode_type    mode_ff, mode_in;
   logic [17:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [3:0]  nib_ff, nib_in;

   logic [3:0][7:0] e_buf;
   logic [1:0]      e_n;

   always_comb begin
      logic       do_plain;
      logic       do_b;
      logic       do_q;
      logic [7:0] v;
      logic [4:0] h;
      logic [23:0] w;
      flush_type  f;

      mode_in  = mode_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      nib_in   = nib_ff;
      e_buf    = '0;
      e_n      = 2'd0;
      do_plain = 1'b0;
      do_b     = 1'b0;
      do_q     = 1'b0;
      v        = sextet_of(in_byte);
      h        = hex_of(in_byte);
      w        = {acc_ff, v[5:0]};
      f        = flush_of(acc_ff, cnt_ff);

      unique case (mode_ff)
         M_SAWEQ: begin
            if (in_byte == CH_QM) mode_in = M_CHARSET;
            else begin
               e_buf[e_n] = CH_EQ; e_n = e_n + 2'd1;
               do_plain = 1'b1;
            end
         end
         M_CHARSET: if (in_byte == CH_QM) mode_in = M_LETTER;
         M_LETTER: begin
            if (in_byte == CH_UQ || in_byte == CH_LQ)      mode_in = M_SKIP_Q;
            else if (in_byte == CH_UB || in_byte == CH_LB) mode_in = M_SKIP_B;
            else                                           mode_in = M_SKIP_X;
         end
         M_SKIP_Q: mode_in = M_Q_DATA;
         M_SKIP_B: begin
            acc_in  = '0;
            cnt_in  = 2'd0;
            mode_in = M_B_DATA;
         end
         M_SKIP_X: mode_in = M_PLAIN;
         M_B_DATA: do_b = 1'b1;
         M_B_QMARK: begin
            if (in_byte == CH_EQ) begin
               for (int i = 0; i < 2; i++) begin
                  if (2'(i) < f.n) begin
                     e_buf[e_n] = f.b[i]; e_n = e_n + 2'd1;
                  end
               end
               acc_in  = '0;
               cnt_in  = 2'd0;
               mode_in = M_PLAIN;
            end else do_b = 1'b1;
         end
         M_B_PAD: begin
            if (in_byte == CH_QM)      mode_in = M_B_PADQ;
            else if (in_byte != CH_EQ) do_plain = 1'b1;
         end
         M_B_PADQ: begin
            if (in_byte == CH_EQ) mode_in = M_PLAIN;
            else begin
               e_buf[e_n] = CH_QM; e_n = e_n + 2'd1;
               do_plain = 1'b1;
            end
         end
         M_Q_DATA: do_q = 1'b1;
         M_Q_QMARK: begin
            if (in_byte == CH_EQ) mode_in = M_PLAIN;
            else                  do_q = 1'b1;
         end
         M_Q_EQ: begin
            mode_in = M_Q_DATA;
            if (!h[4]) begin
               nib_in  = h[3:0];
               mode_in = M_Q_HEX;
            end else if (in_byte != CH_CR && in_byte != CH_LF) begin
               e_buf[e_n] = CH_EQ;   e_n = e_n + 2'd1;
               e_buf[e_n] = in_byte; e_n = e_n + 2'd1;
            end
         end
         M_Q_HEX: begin
            mode_in = M_Q_DATA;
            if (!h[4])                                    e_buf[e_n] = {nib_ff, h[3:0]};
            else if (in_byte == CH_CR || in_byte == CH_LF) e_buf[e_n] = in_byte;
            else                                          e_buf[e_n] = CH_SP;
            e_n = e_n + 2'd1;
         end
         default: do_plain = 1'b1;
      endcase

      if (do_plain) begin
         if (in_byte == CH_EQ) mode_in = M_SAWEQ;
         else begin
            mode_in = M_PLAIN;
            e_buf[e_n] = in_byte; e_n = e_n + 2'd1;
         end
      end

      if (do_b) begin
         if (in_byte == CH_QM) mode_in = M_B_QMARK;
         else begin
            mode_in = M_B_DATA;
            if (v == SextetEnd) begin
               for (int i = 0; i < 2; i++) begin
                  if (2'(i) < f.n) begin
                     e_buf[e_n] = f.b[i]; e_n = e_n + 2'd1;
                  end
               end
               acc_in  = '0;
               cnt_in  = 2'd0;
               mode_in = M_B_PAD;
            end else if (v != NoSextet) begin
               if (cnt_ff == 2'd3) begin
                  e_buf[e_n] = w[23:16]; e_n = e_n + 2'd1;
                  e_buf[e_n] = w[15:8];  e_n = e_n + 2'd1;
                  e_buf[e_n] = w[7:0];   e_n = e_n + 2'd1;
                  acc_in = '0;
                  cnt_in = 2'd0;
               end else begin
                  acc_in = {acc_ff[11:0], v[5:0]};
                  cnt_in = cnt_ff + 2'd1;
               end
            end
         end
      end

      if (do_q) begin
         mode_in = M_Q_DATA;
         if (in_byte == CH_US) begin
            e_buf[e_n] = CH_SP; e_n = e_n + 2'd1;
         end else if (in_byte == CH_QM) mode_in = M_Q_QMARK;
         else if (in_byte == CH_EQ)     mode_in = M_Q_EQ;
         else begin
            e_buf[e_n] = in_byte; e_n = e_n + 2'd1;
         end
      end

      // end of text: emit a held = or ?, or leftover base64 bytes, then back to reset state
      if (in_last) begin
         f = flush_of(acc_in, cnt_in);
         case (mode_in)
            M_SAWEQ: begin
               e_buf[e_n] = CH_EQ; e_n = e_n + 2'd1;
            end
            M_B_DATA, M_B_QMARK: begin
               for (int i = 0; i < 2; i++) begin
                  if (2'(i) < f.n) begin
                     e_buf[e_n] = f.b[i]; e_n = e_n + 2'd1;
                  end
               end
            end
            M_B_PADQ, M_Q_QMARK: begin
               e_buf[e_n] = CH_QM; e_n = e_n + 2'd1;
            end
            default: ;
         endcase
         mode_in = M_PLAIN;
         acc_in  = '0;
         cnt_in  = 2'd0;
         nib_in  = 4'd0;
      end
   end

   assign push        = accept && (e_n != 2'd0 || in_last);
   assign group.bytes = e_buf[mewd_pkg::MaxResults-1:0];
   assign group.count = e_n;
   assign group.last  = in_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_PLAIN;
         acc_ff  <= '0;
         cnt_ff  <= 2'd0;
         nib_ff  <= 4'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         nib_ff  <= nib_in;
      end
   end

endmodule

// ===== sv/mewd_queue.sv =====
module mewd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mewd_pkg::group_type push_group,
   input  logic                pop,
   output mewd_pkg::group_type head,
   output logic                full,
   output logic                not_empty
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   mewd_pkg::group_type [DEPTH-1:0] slot_ff;
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full      = (count_ff == CntW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_group;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CntW'(1);
         else if (pop && !push) count_ff <= count_ff - CntW'(1);
      end
   end

endmodule

// ===== sv/mewd_back.sv =====
module mewd_back (
   input  logic                clock,
   input  logic                reset,
   input  mewd_pkg::group_type head,
   input  logic                not_empty,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                byte_valid,
   output logic                run_last,
   output logic                text_end
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       bval_ff, rlast_ff, tend_ff;

   logic       load;
   logic [1:0] last_idx;
   logic       at_last;

   assign load     = not_empty && (!valid_ff || out_ready);
   assign last_idx = (head.count == 2'd0) ? 2'd0 : head.count - 2'd1;
   assign at_last  = (idx_ff == last_idx);
   assign pop      = load && at_last;
   assign idx_in   = at_last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff  <= (head.count == 2'd0) ? 8'd0 : head.bytes[idx_ff];
         bval_ff  <= (head.count != 2'd0);
         rlast_ff <= at_last;
         tend_ff  <= at_last && head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         if (load)           valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (load) idx_ff <= idx_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign byte_valid = bval_ff;
   assign run_last   = rlast_ff;
   assign text_end   = tend_ff;

endmodule

// ===== sv/mime_encoded_word_decoder_core.sv =====
// streaming decoder for header text holding encoded words =?charset?X?payload?=
// with X one of B, b, Q, q; bytes outside encoded words pass through. one text
// byte is taken per transfer on req_ (tlast on the final byte) and each byte
// yields zero to three result transfers on rsp_; the final byte always yields
// at least one, an empty marker with byte_valid low if it decodes to nothing.
// the parser takes one byte per cycle while the queue is not full; the output
// register sends one result per cycle while rsp_tready is high, so sustained
// rate is one byte per cycle while bytes average at most one result, and a
// byte with k results takes k output transfers. a queue of QUEUE_DEPTH result
// groups sits between parser and output, so req_tready only drops when that
// queue is full.
module mime_encoded_word_decoder_core #(
   parameter int QUEUE_DEPTH = 2   // result groups buffered, 2 to 32
) (
   input  logic       clock,
   input  logic       reset,
   // input stream
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // message_end
   // result stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] text_end
   output logic       rsp_tlast    // run_last
);

   logic                accept;
   logic                push;
   logic                pop;
   logic                full;
   logic                not_empty;
   mewd_pkg::group_type push_group;
   mewd_pkg::group_type head;
   logic                byte_valid;
   logic                text_end;

   // front side stalls only on a full queue
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   // parser: mode tracking, base64 and q decoding of one byte per transfer
   mewd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push),
      .group   (push_group)
   );

   // groups of up to three decoded bytes wait here
   mewd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .full       (full),
      .not_empty  (not_empty)
   );

   // output side: walks a group one result per transfer
   mewd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .not_empty  (not_empty),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .byte_valid (byte_valid),
      .run_last   (rsp_tlast),
      .text_end   (text_end)
   );

   assign rsp_tuser = {text_end, byte_valid};

endmodule
